/* sv/tpm_pkg.sv */
`default_nettype none

package tpm_pkg;

    // Default sizes of the two timestamp stores.
    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 40;

    // Fixed field widths of the request and result channels.
    localparam int OP_W   = 2;
    localparam int TS_W   = 40;
    localparam int OFS_W  = 40;
    localparam int MAX_W  = 24;
    localparam int LIM_W  = MAX_W + 2;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 6;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_APPEND_MIC = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_REF = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND       = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MATCH    = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_NO_MATCH = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIC_RD,
        ST_MIC_ADJ,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Classification of one mic/reference pair, from the interval unit.
    typedef struct packed {
        logic valid;
        logic neg;
        logic pos;
        logic in_range;
    } pair_flags_t;

endpackage

`default_nettype wire

/* sv/timestamp_pair_matcher.sv */
// Timestamp pair matcher.
// Requests arrive on the s_ channel (valid/ready) and each gives exactly one
// result on the m_ channel (valid/ready). An append writes a timestamp to the
// mic or reference store, or reports the store as full; clear empties both
// stores; find searches for the first qualifying mic/reference pair.
// The result of an append or clear shows in the cycle after it is taken.
// A find walks the mic entries one at a time through a single subtract and
// compare unit fed by the reference store's read port. Each mic entry goes
// through a mic read, an offset subtract, one reference entry per cycle and
// then a two-stage drain. The search ends early at the first match. The
// block takes no new request during a find.
// After reset both stores are empty and no result is pending; stored times
// keep whatever they held. A result waits in the output register while the
// receiver stalls; a new request is taken meanwhile only if that result is
// being taken in the same cycle.
`default_nettype none

module timestamp_pair_matcher #(
    parameter int DEPTH     = tpm_pkg::DEPTH_DEF,
    parameter int TIME_BITS = tpm_pkg::TIME_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [tpm_pkg::OP_W-1:0]             s_opcode,
    input  wire logic [tpm_pkg::TS_W-1:0]             s_timestamp,
    input  wire logic signed [tpm_pkg::OFS_W-1:0]     s_offset,
    input  wire logic [tpm_pkg::MAX_W-1:0]            s_max_interval,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [tpm_pkg::STAT_W-1:0]                m_status,
    output logic [tpm_pkg::IDX_W-1:0]                 m_mic_index,
    output logic [tpm_pkg::IDX_W-1:0]                 m_ref_index
);
    import tpm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ((TIME_BITS > TS_W) ? TIME_BITS : TS_W) + 2;

    // Timestamp stores.
    logic [TIME_BITS-1:0] mic_mem [DEPTH];
    logic [TIME_BITS-1:0] ref_mem [DEPTH];
    logic [TIME_BITS-1:0] mic_rdata_reg;
    logic [TIME_BITS-1:0] ref_rdata_reg;
    logic [TIME_BITS-1:0] ts_masked;
    logic                 mic_we;
    logic                 ref_we;

    state_t               state_reg, state_next;
    logic [CW-1:0]        mic_cnt_reg, mic_cnt_next;
    logic [CW-1:0]        ref_cnt_reg, ref_cnt_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic                 behind_reg, behind_next;
    logic                 a_valid_reg, a_valid_next;
    logic [AW-1:0]        a_tag_reg;
    logic signed [OFS_W-1:0] offset_reg, offset_next;
    logic [LIM_W-1:0]     limit_reg, limit_next;
    logic signed [IW-1:0] mic_adj_reg, mic_adj_next;
    logic signed [IW-1:0] mic_ext;
    logic signed [IW-1:0] off_ext;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic [AW-1:0]        res_mi_reg, res_mi_next;
    logic [AW-1:0]        res_ri_reg, res_ri_next;

    logic                 m_valid_reg;
    logic [STAT_W-1:0]    m_status_reg;
    logic [IDX_W-1:0]     m_mic_index_reg;
    logic [IDX_W-1:0]     m_ref_index_reg;
    logic                 out_load;
    logic [STAT_W-1:0]    out_status;
    logic [AW-1:0]        out_mi;
    logic [AW-1:0]        out_ri;

    logic                 accept;
    logic                 out_free;
    logic                 issue;
    logic                 flush;
    pair_flags_t          flags;
    logic [AW-1:0]        b_tag;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign ts_masked = TIME_BITS'(s_timestamp);
    assign mic_ext   = IW'(mic_rdata_reg);
    assign off_ext   = IW'(offset_reg);

    // Store write ports and registered read ports.
    always_ff @(posedge aclk) begin
        if (mic_we) begin
            mic_mem[mic_cnt_reg[AW-1:0]] <= ts_masked;
        end
        mic_rdata_reg <= mic_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_cnt_reg[AW-1:0]] <= ts_masked;
        end
        ref_rdata_reg <= ref_mem[j_reg[AW-1:0]];
    end

    // Pair arithmetic and classification.
    tpm_interval_unit #(
        .TIME_BITS (TIME_BITS),
        .TAG_W     (AW)
    ) u_interval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flush    (flush),
        .in_valid (a_valid_reg),
        .mic_adj  (mic_adj_reg),
        .ref_time (ref_rdata_reg),
        .in_tag   (a_tag_reg),
        .limit    (limit_reg),
        .flags    (flags),
        .out_tag  (b_tag)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mic_cnt_reg <= '0;
            ref_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
            behind_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mic_cnt_reg <= mic_cnt_next;
            ref_cnt_reg <= ref_cnt_next;
            a_valid_reg <= a_valid_next;
            behind_reg  <= behind_next;
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        a_tag_reg      <= j_reg[AW-1:0];
        offset_reg     <= offset_next;
        limit_reg      <= limit_next;
        mic_adj_reg    <= mic_adj_next;
        res_status_reg <= res_status_next;
        res_mi_reg     <= res_mi_next;
        res_ri_reg     <= res_ri_next;
    end

    // Sequencer: next state and control.
    always_comb begin
        state_next      = state_reg;
        mic_cnt_next    = mic_cnt_reg;
        ref_cnt_next    = ref_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        behind_next     = behind_reg;
        offset_next     = offset_reg;
        limit_next      = limit_reg;
        mic_adj_next    = mic_adj_reg;
        res_status_next = res_status_reg;
        res_mi_next     = res_mi_reg;
        res_ri_next     = res_ri_reg;
        mic_we          = 1'b0;
        ref_we          = 1'b0;
        issue           = 1'b0;
        flush           = 1'b0;
        a_valid_next    = 1'b0;
        out_load        = 1'b0;
        out_status      = STATUS_DONE;
        out_mi          = '0;
        out_ri          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_opcode)
                        OP_APPEND_MIC: begin
                            out_load = 1'b1;
                            if (mic_cnt_reg >= CW'(DEPTH)) begin
                                out_status = STATUS_FULL;
                            end else begin
                                mic_we       = 1'b1;
                                mic_cnt_next = mic_cnt_reg + 1'b1;
                            end
                        end
                        OP_APPEND_REF: begin
                            out_load = 1'b1;
                            if (ref_cnt_reg >= CW'(DEPTH)) begin
                                out_status = STATUS_FULL;
                            end else begin
                                ref_we       = 1'b1;
                                ref_cnt_next = ref_cnt_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            out_load     = 1'b1;
                            mic_cnt_next = '0;
                            ref_cnt_next = '0;
                        end
                        OP_FIND: begin
                            offset_next = s_offset;
                            limit_next  = LIM_W'(s_max_interval)
                                        + {1'b0, s_max_interval, 1'b0};
                            i_next      = '0;
                            res_mi_next = '0;
                            res_ri_next = '0;
                            if ((mic_cnt_reg == '0) || (ref_cnt_reg == '0)) begin
                                res_status_next = STATUS_NO_MATCH;
                                state_next      = ST_RESULT;
                            end else begin
                                state_next = ST_MIC_RD;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            // The mic entry is being read from its store.
            ST_MIC_RD: begin
                state_next = ST_MIC_ADJ;
            end

            // Apply the offset once for this mic entry and restart the row.
            ST_MIC_ADJ: begin
                mic_adj_next = mic_ext - off_ext;
                behind_next  = 1'b0;
                j_next       = '0;
                state_next   = ST_SCAN;
            end

            // One reference entry enters per cycle; the decision sits at the
            // end of the interval unit.
            ST_SCAN: begin
                issue = j_reg < ref_cnt_reg;
                if (issue) begin
                    j_next = j_reg + 1'b1;
                end
                a_valid_next = issue;

                if (flags.valid && flags.neg && behind_reg) begin
                    res_status_next = STATUS_MATCH;
                    res_mi_next     = i_reg;
                    res_ri_next     = b_tag - 1'b1;
                    flush           = 1'b1;
                    a_valid_next    = 1'b0;
                    state_next      = ST_RESULT;
                end else if (flags.valid && flags.pos && flags.in_range) begin
                    res_status_next = STATUS_MATCH;
                    res_mi_next     = i_reg;
                    res_ri_next     = b_tag;
                    flush           = 1'b1;
                    a_valid_next    = 1'b0;
                    state_next      = ST_RESULT;
                end else begin
                    if (flags.valid && flags.pos) begin
                        behind_next = 1'b1;
                    end
                    // Row finished without a match: next mic entry or give up.
                    if (!issue && !a_valid_reg && !flags.valid) begin
                        if ((CW'(i_reg) + 1'b1) < mic_cnt_reg) begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_MIC_RD;
                        end else begin
                            res_status_next = STATUS_NO_MATCH;
                            res_mi_next     = '0;
                            res_ri_next     = '0;
                            state_next      = ST_RESULT;
                        end
                    end
                end
            end

            ST_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = res_status_reg;
                    out_mi     = res_mi_reg;
                    out_ri     = res_ri_reg;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg    <= out_status;
            m_mic_index_reg <= IDX_W'(out_mi);
            m_ref_index_reg <= IDX_W'(out_ri);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_mic_index = m_mic_index_reg;
    assign m_ref_index = m_ref_index_reg;

endmodule

`default_nettype wire

/* sv/tpm_interval_unit.sv */
`default_nettype none

module tpm_interval_unit #(
    parameter int TIME_BITS = tpm_pkg::TIME_BITS_DEF,
    parameter int TAG_W     = 6
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                flush,
    input  wire logic                                in_valid,
    input  wire logic signed [((TIME_BITS > tpm_pkg::TS_W) ? TIME_BITS : tpm_pkg::TS_W)+1:0]
                                                     mic_adj,
    input  wire logic [TIME_BITS-1:0]                ref_time,
    input  wire logic [TAG_W-1:0]                    in_tag,
    input  wire logic [tpm_pkg::LIM_W-1:0]           limit,
    output tpm_pkg::pair_flags_t                     flags,
    output logic [TAG_W-1:0]                         out_tag
);
    import tpm_pkg::*;

    localparam int IW    = ((TIME_BITS > TS_W) ? TIME_BITS : TS_W) + 2;
    localparam int CMP_W = IW + 1;

    logic                    valid_reg;
    logic signed [IW-1:0]    interval_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic signed [IW-1:0]    ref_ext;
    logic signed [IW-1:0]    interval_next;
    logic signed [CMP_W-1:0] twice_interval;
    logic signed [CMP_W-1:0] limit_ext;

    // The shared subtractor: interval = (mic - offset) - ref.
    assign ref_ext       = IW'(ref_time);
    assign interval_next = mic_adj - ref_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid && !flush;
        end
    end

    always_ff @(posedge aclk) begin
        interval_reg <= interval_next;
        tag_reg      <= in_tag;
    end

    // Classify the registered interval and check it against 1.5 times the maximum.
    assign twice_interval = {interval_reg, 1'b0};
    assign limit_ext      = CMP_W'(limit);

    always_comb begin
        flags.valid    = valid_reg;
        flags.neg      = interval_reg[IW-1];
        flags.pos      = !interval_reg[IW-1] && (|interval_reg);
        flags.in_range = twice_interval < limit_ext;
    end

    assign out_tag = tag_reg;

endmodule

`default_nettype wire

/* sv/tpm_checker.sv */
`default_nettype none

module tpm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic [tpm_pkg::OP_W-1:0]         s_opcode,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [tpm_pkg::STAT_W-1:0]       m_status,
    input wire logic [tpm_pkg::IDX_W-1:0]        m_mic_index,
    input wire logic [tpm_pkg::IDX_W-1:0]        m_ref_index
);
    import tpm_pkg::*;

    // Indices are only meaningful on a match.
    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_MATCH)) |->
        ((m_mic_index == '0) && (m_ref_index == '0)))
        else $error("nonzero index on a result that is not a match");

    // An append or clear request answers in the next cycle.
    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode != OP_FIND)) |=> m_valid)
        else $error("append or clear result missing in the next cycle");

    // A find keeps the block busy for at least the following cycle.
    a_find_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_FIND)) |=> !s_ready)
        else $error("request taken right after a find");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_status) && $stable(m_mic_index) && $stable(m_ref_index)))
        else $error("stalled result changed");

endmodule

bind timestamp_pair_matcher tpm_checker u_tpm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_opcode    (s_opcode),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_mic_index (m_mic_index),
    .m_ref_index (m_ref_index)
);

`default_nettype wire

/* tb/timestamp_pair_matcher_test.sv */
`timescale 1ns / 100ps

module timestamp_pair_matcher_test;
    import tpm_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 20;
    // Leave room for a full search, with stalls on top.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  mic_index;
        logic [IDX_W-1:0]  ref_index;
    } outcome_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_opcode       = OP_APPEND_MIC;
    logic [TS_W-1:0]         s_timestamp    = '0;
    logic signed [OFS_W-1:0] s_offset       = '0;
    logic [MAX_W-1:0]        s_max_interval = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [STAT_W-1:0]       m_status;
    logic [IDX_W-1:0]        m_mic_index;
    logic [IDX_W-1:0]        m_ref_index;

    // Shadow copy of both timestamp stores.
    logic [TS_W-1:0] mic_history [DEPTH_DEF];
    logic [TS_W-1:0] ref_history [DEPTH_DEF];
    int              mic_fill = 0;
    int              ref_fill = 0;

    outcome_t pending_outcomes [$];
    int       request_count = 0;
    int       fail_count    = 0;
    bit       no_idle       = 1'b0;

    // Result-side stall bookkeeping, owned by the receiver process.
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    timestamp_pair_matcher u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_timestamp    (s_timestamp),
        .s_offset       (s_offset),
        .s_max_interval (s_max_interval),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_mic_index    (m_mic_index),
        .m_ref_index    (m_ref_index)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(3, 1);
        end else if (roll < 97) begin
            return $urandom_range(20, 4);
        end
        return $urandom_range(150, 40);
    endfunction

    function automatic logic [TS_W-1:0] rand40();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TS_W-1:0];
    endfunction

    // Applies one request to the shadow stores and returns the result it gives.
    function automatic outcome_t match_outcome(input logic [OP_W-1:0] op,
            input logic [TS_W-1:0] ts, input logic signed [OFS_W-1:0] ofs,
            input logic [MAX_W-1:0] mx);
        outcome_t res;
        longint   gap_us;
        longint   bound;
        bit       behind;
        res = '{STATUS_DONE, '0, '0};
        case (op)
            OP_APPEND_MIC: begin
                if (mic_fill >= DEPTH_DEF) begin
                    res.status = STATUS_FULL;
                end else begin
                    mic_history[mic_fill] = ts;
                    mic_fill++;
                end
            end
            OP_APPEND_REF: begin
                if (ref_fill >= DEPTH_DEF) begin
                    res.status = STATUS_FULL;
                end else begin
                    ref_history[ref_fill] = ts;
                    ref_fill++;
                end
            end
            OP_CLEAR: begin
                mic_fill = 0;
                ref_fill = 0;
            end
            OP_FIND: begin
                res.status = STATUS_NO_MATCH;
                bound = 3 * longint'(mx);
                for (int i = 0; i < mic_fill; i++) begin
                    behind = 1'b0;
                    for (int j = 0; j < ref_fill; j++) begin
                        gap_us = longint'(mic_history[i]) - longint'(ofs)
                                 - longint'(ref_history[j]);
                        if (gap_us < 0) begin
                            // Crossed over after running behind: take the previous entry.
                            if (behind) begin
                                res.status    = STATUS_MATCH;
                                res.mic_index = IDX_W'(i);
                                res.ref_index = IDX_W'(j - 1);
                                return res;
                            end
                        end else if (gap_us > 0) begin
                            behind = 1'b1;
                            if (2 * gap_us < bound) begin
                                res.status    = STATUS_MATCH;
                                res.mic_index = IDX_W'(i);
                                res.ref_index = IDX_W'(j);
                                return res;
                            end
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("%s", msg);
        end
        fail_count++;
    endtask

    // Offers one request after a random gap and records its outcome once taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts,
            input logic signed [OFS_W-1:0] ofs, input logic [MAX_W-1:0] mx);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_timestamp    <= ts;
        s_offset       <= ofs;
        s_max_interval <= mx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_outcomes.push_back(match_outcome(op, ts, ofs, mx));
        request_count++;
    endtask

    // Unused fields always carry random values.
    task automatic append_mic(input logic [TS_W-1:0] ts);
        send_request(OP_APPEND_MIC, ts, rand40(), MAX_W'($urandom));
    endtask

    task automatic append_ref(input logic [TS_W-1:0] ts);
        send_request(OP_APPEND_REF, ts, rand40(), MAX_W'($urandom));
    endtask

    task automatic clear_stores();
        send_request(OP_CLEAR, rand40(), rand40(), MAX_W'($urandom));
    endtask

    task automatic find_pair(input logic signed [OFS_W-1:0] ofs, input logic [MAX_W-1:0] mx);
        send_request(OP_FIND, rand40(), ofs, mx);
    endtask

    task automatic drain_outcomes();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // A find on empty stores, and with only one store empty, never matches.
    task automatic test_empty_stores();
        find_pair(rand40(), MAX_W'($urandom));
        append_mic(rand40());
        find_pair(rand40(), MAX_W'($urandom));
        clear_stores();
        append_ref(rand40());
        find_pair(rand40(), MAX_W'($urandom));
        clear_stores();
    endtask

    // Zero intervals skipped, negative before and after running behind,
    // positive out of range, a zero limit, and the offset extremes.
    task automatic test_interval_rules();
        append_mic(TS_W'(1000));
        append_ref(TS_W'(1000));
        append_ref(TS_W'(1100));
        append_ref(TS_W'(950));
        append_ref(TS_W'(960));
        append_ref(TS_W'(1200));
        find_pair(OFS_W'(0), MAX_W'(10));
        find_pair(OFS_W'(0), MAX_W'(34));
        find_pair(OFS_W'(0), MAX_W'(0));
        find_pair(-OFS_W'(60), MAX_W'(10));
        find_pair({1'b1, {(OFS_W-1){1'b0}}}, {MAX_W{1'b1}});
        find_pair({1'b0, {(OFS_W-1){1'b1}}}, {MAX_W{1'b1}});
        append_mic({TS_W{1'b1}});
        append_mic(TS_W'(0));
        find_pair({1'b0, {(OFS_W-1){1'b1}}}, {MAX_W{1'b1}});
        clear_stores();
    endtask

    // Both stores filled to the top, a match on the last pair, dropped
    // appends, then a search that runs through every pair.
    task automatic test_full_stores();
        logic [TS_W-1:0] t0;
        t0 = rand40() >> 1;
        for (int k = 0; k < DEPTH_DEF - 1; k++) begin
            append_mic(t0);
        end
        append_mic(t0 + TS_W'(500));
        for (int k = 0; k < DEPTH_DEF - 1; k++) begin
            append_ref(t0 + TS_W'(500));
        end
        append_ref(t0 + TS_W'(400));
        append_mic(rand40());
        append_ref(rand40());
        find_pair(OFS_W'(0), MAX_W'(100));
        find_pair({1'b1, {(OFS_W-1){1'b0}}}, MAX_W'(0));
        clear_stores();
        drain_outcomes();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        no_idle = 1'b1;
        hold_req++;
        for (int k = 0; k < 6; k++) begin
            send_request(OP_W'($urandom_range(3)), rand40(), rand40(), MAX_W'($urandom));
        end
        drain_outcomes();
        no_idle = 1'b0;
        clear_stores();
    endtask

    // Mostly rounds of appends with reference times lined up against the mic
    // times, followed by finds; the rest is fully random requests.
    task automatic test_random_traffic();
        int     first;
        int     n_mic;
        int     n_ref;
        int     roll;
        longint base;
        longint lag;
        longint mic_t;
        logic [MAX_W-1:0] mx;
        first = request_count;
        while (request_count - first < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(7) == 0);
            if ($urandom_range(4) == 0) begin
                send_request(OP_W'($urandom_range(3)), rand40(), rand40(),
                             MAX_W'($urandom));
            end else begin
                roll = $urandom_range(9);
                if (roll == 0) begin
                    base = longint'($urandom_range(5000));
                end else if (roll == 1) begin
                    base = longint'({TS_W{1'b1}}) - longint'($urandom_range(5000));
                end else begin
                    base = longint'(rand40());
                end
                roll = $urandom_range(19);
                if (roll < 6) begin
                    lag = 0;
                end else if (roll < 15) begin
                    lag = longint'($urandom_range(10000)) - 5000;
                end else begin
                    lag = longint'($signed(rand40()));
                end
                if ($urandom_range(3) != 0) begin
                    clear_stores();
                end
                n_mic = $urandom_range(6, 1);
                n_ref = $urandom_range(10, 1);
                mic_t = base;
                while (n_mic + n_ref > 0) begin
                    if (n_mic > 0 && (n_ref == 0 || $urandom_range(1) == 1)) begin
                        append_mic(TS_W'(mic_t));
                        mic_t += longint'($urandom_range(2000));
                        n_mic--;
                    end else begin
                        append_ref(TS_W'(mic_t - lag + longint'($urandom_range(6000)) - 3000));
                        n_ref--;
                    end
                end
                repeat ($urandom_range(3, 1)) begin
                    roll = $urandom_range(9);
                    if (roll < 7) begin
                        mx = MAX_W'($urandom_range(2000));
                    end else if (roll < 9) begin
                        mx = MAX_W'($urandom_range(50));
                    end else begin
                        mx = MAX_W'($urandom);
                    end
                    if ($urandom_range(3) == 0) begin
                        find_pair(OFS_W'(lag + longint'($urandom_range(200)) - 100), mx);
                    end else begin
                        find_pair(OFS_W'(lag), mx);
                    end
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, plus one long hold when the stall test asks.
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // Each result taken is compared with the oldest outstanding outcome.
    always @(posedge aclk) begin : check_outcomes
        outcome_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                note_failure($sformatf("Unexpected result: status %0d mic %0d ref %0d",
                                       m_status, m_mic_index, m_ref_index));
            end else begin
                want = pending_outcomes.pop_front();
                if (m_status !== want.status || m_mic_index !== want.mic_index
                        || m_ref_index !== want.ref_index) begin
                    note_failure($sformatf(
                        "Mismatch at %0t: status %0d/%0d mic %0d/%0d ref %0d/%0d (exp/got)",
                        $realtime, want.status, m_status, want.mic_index, m_mic_index,
                        want.ref_index, m_ref_index));
                end
            end
        end
    end

    // Ends the run if nothing moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_stores();
        test_interval_rules();
        test_full_stores();
        test_output_stall();
        test_random_traffic();
        drain_outcomes();

        if (pending_outcomes.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_outcomes.size()));
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* timestamp_pair_matcher.f */
sv/tpm_pkg.sv
sv/tpm_interval_unit.sv
sv/timestamp_pair_matcher.sv
sv/tpm_checker.sv
tb/timestamp_pair_matcher_test.sv
